// ===== hdl/gcd_pkg.sv =====
`default_nettype none

package gcd_pkg;

    // Fixed-point setup
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STAGES   = 20;

    // CORDIC datapath width (sign, integer headroom, fraction)
    localparam int CW    = ANGLE_FRAC_BITS + 5;
    localparam int STG_W = $clog2(CORDIC_STAGES);
    localparam int PW    = 2 * CW;

    // Square root: result bits, bit index width, remainder width, input width
    localparam int SQ_BITS = ANGLE_FRAC_BITS + 1;
    localparam int SQK_W   = $clog2(SQ_BITS);
    localparam int RW      = 2 * ANGLE_FRAC_BITS + 3;
    localparam int AW      = 2 * ANGLE_FRAC_BITS + 1;

    // Angle front end: degrees with 17 fraction bits
    localparam int DW     = 26;
    localparam int RDW    = 27;
    localparam int RGW    = 25;
    localparam int KW     = 28;
    localparam int MW     = RGW + KW;
    localparam int DEG_SH = 49 - ANGLE_FRAC_BITS;

    localparam logic signed [RDW-1:0] DEG_TURN    = 27'sd47185920;
    localparam logic signed [RDW-1:0] DEG_HALF    = 27'sd23592960;
    localparam logic signed [RDW-1:0] DEG_QUARTER = 27'sd11796480;
    localparam logic signed [KW-1:0]  DEG2RAD_Q32 = 28'sd74961321;

    localparam longint INV_GAIN_W =
        (64'd652032874 + (64'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS);

    localparam longint ATAN_Q30 [32] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000
    };

    // Distance scaling
    localparam int RADIUS_W = 16;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd6371;
    localparam int DIST_W = 24;
    localparam int DPW    = RADIUS_W + CW - 1;
    localparam int DSW    = DPW + 10;

    typedef struct packed {
        logic                 neg;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic [RW-1:0]      rem;
        logic [SQ_BITS-1:0] root;
    } sqrt_t;

    // Arctangent of 2^-i, rounded to the working fraction
    function automatic logic signed [CW-1:0] atan_w(input logic [STG_W-1:0] i);
        longint t;
        t = (ATAN_Q30[i] + (64'sd1 <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
        return CW'(t);
    endfunction

    // Shift right by the fraction width, rounding half away from zero
    function automatic logic signed [PW-1:0] rnd_shr_w(input logic signed [PW-1:0] v);
        logic [PW-1:0] m;
        m = v[PW-1] ? PW'(-v) : PW'(v);
        m = (m + (PW'(1) << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS;
        return v[PW-1] ? PW'(-m) : PW'(m);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/gcd_angle_prep.sv =====
`default_nettype none

module gcd_angle_prep (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic signed [gcd_pkg::DW-1:0] deg_in,
    output gcd_pkg::cordic_t                   rot_out
);
    import gcd_pkg::*;

    logic signed [RDW-1:0] d_ext;
    logic signed [RDW-1:0] wrap;
    logic signed [RDW-1:0] fold;
    logic                  fold_neg;

    logic signed [RGW-1:0] red_reg;
    logic                  neg_a_reg;
    logic signed [MW-1:0]  prod_next;
    logic signed [MW-1:0]  prod_reg;
    logic                  neg_b_reg;
    logic [MW-1:0]         mag;
    logic [MW-1:0]         zmag;
    cordic_t               rot_next;
    cordic_t               rot_reg;

    // wrap to (-180, 180], then fold into [-90, 90] with sign flip
    always_comb begin
        d_ext = RDW'(deg_in);
        wrap  = d_ext;
        if (d_ext > DEG_HALF) begin
            wrap = d_ext - DEG_TURN;
        end else if (d_ext <= -DEG_HALF) begin
            wrap = d_ext + DEG_TURN;
        end
        fold     = wrap;
        fold_neg = 1'b0;
        if (wrap > DEG_QUARTER) begin
            fold     = wrap - DEG_HALF;
            fold_neg = 1'b1;
        end else if (wrap < -DEG_QUARTER) begin
            fold     = wrap + DEG_HALF;
            fold_neg = 1'b1;
        end
    end

    assign prod_next = red_reg * DEG2RAD_Q32;

    // degrees to radians, rounded half away from zero
    always_comb begin
        mag  = prod_reg[MW-1] ? MW'(-prod_reg) : MW'(prod_reg);
        zmag = (mag + (MW'(1) << (DEG_SH - 1))) >> DEG_SH;
        rot_next.neg = neg_b_reg;
        rot_next.x   = CW'(INV_GAIN_W);
        rot_next.y   = '0;
        rot_next.z   = prod_reg[MW-1] ? CW'(-zmag) : CW'(zmag);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            red_reg   <= RGW'(fold);
            neg_a_reg <= fold_neg;
            prod_reg  <= prod_next;
            neg_b_reg <= neg_a_reg;
            rot_reg   <= rot_next;
        end
    end

    assign rot_out = rot_reg;

endmodule

`default_nettype wire

// ===== hdl/gcd_cordic_cell.sv =====
`default_nettype none

module gcd_cordic_cell (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic                         vect_mode,
    input  wire logic [gcd_pkg::STG_W-1:0]    stage,
    input  gcd_pkg::cordic_t                  din,
    output gcd_pkg::cordic_t                  dout
);
    import gcd_pkg::*;

    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [CW-1:0] x_sh;
    logic signed [CW-1:0] y_sh;
    logic signed [CW-1:0] at;
    logic                 ccw;
    cordic_t              cell_next;
    cordic_t              cell_reg;

    // rotation: steer by sign of z; vectoring: drive y toward zero
    always_comb begin
        x_in = din.x;
        y_in = din.y;
        x_sh = x_in >>> stage;
        y_sh = y_in >>> stage;
        at   = atan_w(stage);
        ccw  = vect_mode ? !(!y_in[CW-1] && (|y_in)) : !din.z[CW-1];
        cell_next.neg = din.neg;
        if (ccw) begin
            cell_next.x = x_in - y_sh;
            cell_next.y = y_in + x_sh;
            cell_next.z = din.z - at;
        end else begin
            cell_next.x = x_in + y_sh;
            cell_next.y = y_in - x_sh;
            cell_next.z = din.z + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

`default_nettype wire

// ===== hdl/gcd_sqrt_cell.sv =====
`default_nettype none

module gcd_sqrt_cell (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic [gcd_pkg::SQK_W-1:0]  bit_pos,
    input  gcd_pkg::sqrt_t                  din,
    output gcd_pkg::sqrt_t                  dout
);
    import gcd_pkg::*;

    logic [SQK_W:0] sh1;
    logic [RW-1:0]  trial;
    sqrt_t          cell_next;
    sqrt_t          cell_reg;

    // one result bit: try (root + 2^k)^2 against the remainder
    always_comb begin
        sh1       = {1'b0, bit_pos} + 1'b1;
        trial     = (RW'(din.root) << sh1) + (RW'(1) << {bit_pos, 1'b0});
        cell_next = din;
        if (din.rem >= trial) begin
            cell_next.rem  = din.rem - trial;
            cell_next.root = din.root | (SQ_BITS'(1) << bit_pos);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

`default_nettype wire

// ===== hdl/great_circle_distance.sv =====
// Haversine great-circle distance, fully pipelined.
// s_ channel: one transaction per point pair (lat/lon in degrees, 16 fraction bits).
// m_ channel: one transaction per pair, distance in km with 8 fraction bits,
//   saturated at the 24-bit maximum.
// cfg_wen/cfg_wdata: earth radius in whole km; write only while the pipe is empty.
// Throughput: one pair per cycle while m_ is not stalled. Stages in order:
//   1 input stage, 3 degree-to-radian stages, a chain of
//   CORDIC_STAGES rotation cells (four lanes: sin dlat/2, sin dlon/2, cos lat1,
//   cos lat2), 4 product stages, a 17-cell square root chain (two lanes),
//   CORDIC_STAGES vectoring cells for the arctangent, and 2 scaling stages.
// Every stage advances on one shared enable; the last stage is the output register.
// Receiver stall: when m_tvalid is high and m_tready low the whole pipe holds,
//   s_tready drops, and no transaction is lost or repeated; bubbles keep their places.
// Reset (aresetn low, synchronous): all valid bits clear, the pipe is empty and the
//   radius returns to 6371 km.
`default_nettype none

module great_circle_distance (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    // first_lat[23:0], first_lon[48:24], second_lat[72:49], second_lon[97:73], zero pad
    input  wire logic [103:0]                     s_tdata,
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    // distance_km[23:0]
    output      logic [23:0]                      m_tdata,
    input  wire logic                             cfg_wen,
    input  wire logic [gcd_pkg::RADIUS_W-1:0]     cfg_wdata
);
    import gcd_pkg::*;

    // valid bit positions along the pipe
    localparam int L_PREP = 3;
    localparam int L_SC   = L_PREP + CORDIC_STAGES;
    localparam int L_M4   = L_SC + 4;
    localparam int L_SQ   = L_M4 + SQ_BITS;
    localparam int L_VC   = L_SQ + CORDIC_STAGES;
    localparam int L_OUT  = L_VC + 2;
    localparam int NPIPE  = L_OUT + 1;

    localparam logic signed [PW:0] ONE2   = (PW + 1)'(1) << (2 * ANGLE_FRAC_BITS);
    localparam logic [AW-1:0]      ONE2_A = AW'(1) << (2 * ANGLE_FRAC_BITS);
    localparam logic [DSW-1:0]     DIST_MAX = {{(DSW - DIST_W){1'b0}}, {DIST_W{1'b1}}};

    logic en;
    logic [NPIPE-1:0] vld_reg;
    logic [NPIPE-1:0] vld_next;
    logic [RADIUS_W-1:0] radius_reg;
    logic [RADIUS_W-1:0] radius_next;

    // input fields
    logic signed [23:0] first_lat;
    logic signed [24:0] first_lon;
    logic signed [23:0] second_lat;
    logic signed [24:0] second_lon;

    // half-angle differences and doubled latitudes, 17 fraction bits
    logic signed [DW-1:0] dlat_reg;
    logic signed [DW-1:0] dlon_reg;
    logic signed [DW-1:0] lat1_reg;
    logic signed [DW-1:0] lat2_reg;

    cordic_t sc_bus [4][CORDIC_STAGES+1];
    sqrt_t   sqa_bus [SQ_BITS+1];
    sqrt_t   sqb_bus [SQ_BITS+1];
    cordic_t vc_bus  [CORDIC_STAGES+1];

    // product stages
    logic signed [CW-1:0] cos1;
    logic signed [CW-1:0] cos2;
    logic signed [PW-1:0] sdl_sq_reg;
    logic signed [PW-1:0] sdn_sq_reg;
    logic signed [PW-1:0] c12_raw_reg;
    logic signed [CW-1:0] c12_reg;
    logic signed [CW-1:0] sn2_reg;
    logic signed [PW-1:0] sdl_sq2_reg;
    logic signed [PW-1:0] cs_prod_reg;
    logic signed [PW-1:0] sdl_sq3_reg;
    logic signed [PW:0]   a_sum;
    logic [AW-1:0]        a_next;
    logic [AW-1:0]        a_reg;

    // scaling stages
    logic signed [CW-1:0] ang;
    logic [CW-2:0]        ang_clamp;
    logic [DPW-1:0]       dist_prod_reg;
    logic [DSW-1:0]       dist_wide;
    logic [DIST_W-1:0]    dist_next;
    logic [DIST_W-1:0]    dist_reg;

    assign en       = !vld_reg[L_OUT] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[L_OUT];
    assign m_tdata  = dist_reg;

    assign first_lat  = s_tdata[23:0];
    assign first_lon  = s_tdata[48:24];
    assign second_lat = s_tdata[72:49];
    assign second_lon = s_tdata[97:73];

    always_comb begin
        vld_next    = {vld_reg[NPIPE-2:0], s_tvalid};
        radius_next = cfg_wen ? cfg_wdata : radius_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            radius_reg <= RADIUS_RESET;
        end else begin
            radius_reg <= radius_next;
            if (en) begin
                vld_reg <= vld_next;
            end
        end
    end

    // input stage: angles in degrees with 17 fraction bits
    always_ff @(posedge aclk) begin
        if (en) begin
            dlat_reg <= DW'(first_lat) - DW'(second_lat);
            dlon_reg <= DW'(first_lon) - DW'(second_lon);
            lat1_reg <= DW'(first_lat) <<< 1;
            lat2_reg <= DW'(second_lat) <<< 1;
        end
    end

    gcd_angle_prep u_prep_dlat (.aclk(aclk), .en(en), .deg_in(dlat_reg), .rot_out(sc_bus[0][0]));
    gcd_angle_prep u_prep_dlon (.aclk(aclk), .en(en), .deg_in(dlon_reg), .rot_out(sc_bus[1][0]));
    gcd_angle_prep u_prep_lat1 (.aclk(aclk), .en(en), .deg_in(lat1_reg), .rot_out(sc_bus[2][0]));
    gcd_angle_prep u_prep_lat2 (.aclk(aclk), .en(en), .deg_in(lat2_reg), .rot_out(sc_bus[3][0]));

    // sine/cosine chains, four lanes side by side
    for (genvar l = 0; l < 4; l++) begin : g_sc_lane
        for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_sc_cell
            gcd_cordic_cell u_cell (
                .aclk      (aclk),
                .en        (en),
                .vect_mode (1'b0),
                .stage     (STG_W'(g)),
                .din       (sc_bus[l][g]),
                .dout      (sc_bus[l][g+1])
            );
        end
    end

    // fold sign back onto the cosines; squares do not need it
    always_comb begin
        cos1 = sc_bus[2][CORDIC_STAGES].neg ? -sc_bus[2][CORDIC_STAGES].x
                                            : sc_bus[2][CORDIC_STAGES].x;
        cos2 = sc_bus[3][CORDIC_STAGES].neg ? -sc_bus[3][CORDIC_STAGES].x
                                            : sc_bus[3][CORDIC_STAGES].x;
    end

    // a = sin^2(dlat/2) + round(cos1*cos2) * round(sin^2(dlon/2)), clamped to [0, 1]
    always_comb begin
        a_sum = (PW + 1)'(sdl_sq3_reg) + (PW + 1)'(cs_prod_reg);
        if (a_sum[PW]) begin
            a_next = '0;
        end else if (a_sum > ONE2) begin
            a_next = ONE2_A;
        end else begin
            a_next = AW'(a_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sdl_sq_reg  <= PW'(sc_bus[0][CORDIC_STAGES].y) * PW'(sc_bus[0][CORDIC_STAGES].y);
            sdn_sq_reg  <= PW'(sc_bus[1][CORDIC_STAGES].y) * PW'(sc_bus[1][CORDIC_STAGES].y);
            c12_raw_reg <= PW'(cos1) * PW'(cos2);
            c12_reg     <= CW'(rnd_shr_w(c12_raw_reg));
            sn2_reg     <= CW'(rnd_shr_w(sdn_sq_reg));
            sdl_sq2_reg <= sdl_sq_reg;
            cs_prod_reg <= PW'(c12_reg) * PW'(sn2_reg);
            sdl_sq3_reg <= sdl_sq2_reg;
            a_reg       <= a_next;
        end
    end

    // floor square roots of a and 1 - a
    assign sqa_bus[0] = '{rem: RW'(a_reg), root: '0};
    assign sqb_bus[0] = '{rem: RW'(ONE2_A - a_reg), root: '0};

    for (genvar g = 0; g < SQ_BITS; g++) begin : g_sq_cell
        gcd_sqrt_cell u_sqa (
            .aclk    (aclk),
            .en      (en),
            .bit_pos (SQK_W'(SQ_BITS - 1 - g)),
            .din     (sqa_bus[g]),
            .dout    (sqa_bus[g+1])
        );
        gcd_sqrt_cell u_sqb (
            .aclk    (aclk),
            .en      (en),
            .bit_pos (SQK_W'(SQ_BITS - 1 - g)),
            .din     (sqb_bus[g]),
            .dout    (sqb_bus[g+1])
        );
    end

    // arctangent of sqrt(a) / sqrt(1 - a) by vectoring
    assign vc_bus[0] = '{neg: 1'b0,
                         x: CW'(sqb_bus[SQ_BITS].root),
                         y: CW'(sqa_bus[SQ_BITS].root),
                         z: '0};

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vc_cell
        gcd_cordic_cell u_cell (
            .aclk      (aclk),
            .en        (en),
            .vect_mode (1'b1),
            .stage     (STG_W'(g)),
            .din       (vc_bus[g]),
            .dout      (vc_bus[g+1])
        );
    end

    // distance = round(R * angle * 512 / 2^W), saturated
    always_comb begin
        ang       = vc_bus[CORDIC_STAGES].z;
        ang_clamp = ang[CW-1] ? '0 : ang[CW-2:0];
        dist_wide = ({1'b0, dist_prod_reg, 9'b0} + (DSW'(1) << (ANGLE_FRAC_BITS - 1)))
                    >> ANGLE_FRAC_BITS;
        dist_next = (dist_wide > DIST_MAX) ? {DIST_W{1'b1}} : dist_wide[DIST_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_prod_reg <= DPW'(radius_reg) * DPW'(ang_clamp);
            dist_reg      <= dist_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_reset_empties : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("pipe not empty after reset");

    a_stall_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(vld_reg))
        else $error("pipe moved during stall");

    a_term_range : assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[L_M4] |-> (a_reg <= ONE2_A))
        else $error("haversine term above one");

    a_root_range : assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[L_SQ] |-> (sqa_bus[SQ_BITS].root <= (SQ_BITS'(1) << ANGLE_FRAC_BITS)))
        else $error("square root above one");
`endif

endmodule

`default_nettype wire
